### src/gtv_pkg.sv
// Shared types and constants of the genotype field validator.
package gtv_pkg;

  localparam int SymbolW = 8;
  localparam int StatusW = 3;
  localparam int OffsetW = 16;
  localparam int MaxIdxW = 20;
  localparam int AccumW  = 24;
  localparam int PhaseW  = 3;
  localparam int SepW    = 2;

  localparam logic [SymbolW-1:0] SymNul   = 8'h00;
  localparam logic [SymbolW-1:0] SymDot   = 8'h2E;
  localparam logic [SymbolW-1:0] SymSlash = 8'h2F;
  localparam logic [SymbolW-1:0] SymPipe  = 8'h7C;
  localparam logic [SymbolW-1:0] SymZero  = 8'h30;
  localparam logic [SymbolW-1:0] SymNine  = 8'h39;

  localparam logic [AccumW-1:0]  IndexLimit   = 24'd1000000;
  localparam logic [MaxIdxW-1:0] MaxIdxReset  = 20'd1000000;

  // Parser phases.
  localparam logic [PhaseW-1:0] PhFirst      = 3'd0;
  localparam logic [PhaseW-1:0] PhNext       = 3'd1;
  localparam logic [PhaseW-1:0] PhIndex      = 3'd2;
  localparam logic [PhaseW-1:0] PhDoneAllele = 3'd3;
  localparam logic [PhaseW-1:0] PhSkip       = 3'd4;

  // Separator kinds.
  localparam logic [SepW-1:0] SepNone  = 2'd0;
  localparam logic [SepW-1:0] SepSlash = 2'd1;
  localparam logic [SepW-1:0] SepPipe  = 2'd2;

  // Result status codes.
  localparam logic [StatusW-1:0] StOk        = 3'd0;
  localparam logic [StatusW-1:0] StEmpty     = 3'd1;
  localparam logic [StatusW-1:0] StOverflow  = 3'd2;
  localparam logic [StatusW-1:0] StAboveMax  = 3'd3;
  localparam logic [StatusW-1:0] StExpected  = 3'd4;
  localparam logic [StatusW-1:0] StAfter     = 3'd5;
  localparam logic [StatusW-1:0] StMixed     = 3'd6;
  localparam logic [StatusW-1:0] StTrailing  = 3'd7;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [OffsetW-1:0] error_offset;
  } gtv_result_t;

endpackage

### src/gtv_parse_core.sv
// Per-byte parser state and its next-state logic.
module gtv_parse_core #(
  parameter int MAX_LEN = 65535
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [gtv_pkg::SymbolW-1:0]   symbol_i,
  input  logic [gtv_pkg::MaxIdxW-1:0]   max_allele_index_i,
  output logic                          result_valid_o,
  output gtv_pkg::gtv_result_t          result_o
);
  import gtv_pkg::*;

  localparam int PosW    = $clog2(MAX_LEN + 1);
  localparam int CmpW    = (PosW > OffsetW) ? PosW : OffsetW;
  localparam logic [PosW-1:0] MaxLenV = PosW'(MAX_LEN);
  localparam logic [CmpW-1:0] OffMaxV = CmpW'({OffsetW{1'b1}});

  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [AccumW-1:0]  accum_q, accum_d;
  logic [SepW-1:0]    sep_q, sep_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [StatusW-1:0] err_code_q, err_code_d;
  logic [PosW-1:0]    err_off_q, err_off_d;

  logic               is_digit;
  logic [3:0]         digit;
  logic [AccumW+3:0]  accum_next;
  logic               above_max;
  logic [SepW-1:0]    sym_sep;
  logic [StatusW-1:0] fin_code;
  logic [PosW-1:0]    fin_off;
  logic [CmpW-1:0]    fin_off_ext;

  assign is_digit   = (symbol_i >= SymZero) && (symbol_i <= SymNine);
  assign digit      = 4'(symbol_i - SymZero);
  assign accum_next = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0}
                    + {(AccumW)'(0), digit};
  assign above_max  = accum_q > AccumW'(max_allele_index_i);
  assign sym_sep    = (symbol_i == SymSlash) ? SepSlash :
                      (symbol_i == SymPipe)  ? SepPipe  : SepNone;

  // Final status when the terminating byte arrives.
  always_comb begin
    fin_code = err_code_q;
    fin_off  = err_off_q;
    unique case (phase_q)
      PhFirst: begin
        fin_code = StEmpty;
        fin_off  = '0;
      end
      PhNext: begin
        fin_code = StTrailing;
        fin_off  = pos_q;
      end
      PhIndex: begin
        if (above_max) begin
          fin_code = StAboveMax;
          fin_off  = '0;
        end
      end
      default: ;
    endcase
  end

  assign fin_off_ext = CmpW'(fin_off);
  assign result_valid_o = accept_i && (symbol_i == SymNul);
  always_comb begin
    result_o.status = fin_code;
    if (fin_code == StOk) begin
      result_o.error_offset = '0;
    end else if (fin_off_ext > OffMaxV) begin
      result_o.error_offset = '1;
    end else begin
      result_o.error_offset = OffsetW'(fin_off_ext);
    end
  end

  always_comb begin
    phase_d    = phase_q;
    accum_d    = accum_q;
    sep_d      = sep_q;
    pos_d      = pos_q;
    err_code_d = err_code_q;
    err_off_d  = err_off_q;
    if (accept_i) begin
      if (symbol_i == SymNul) begin
        phase_d    = PhFirst;
        accum_d    = '0;
        sep_d      = SepNone;
        pos_d      = '0;
        err_code_d = StOk;
        err_off_d  = '0;
      end else begin
        if (pos_q < MaxLenV) begin
          pos_d = pos_q + 1'b1;
        end
        // Errors are only raised outside the skip phase, so the first one sticks.
        unique case (phase_q) inside
          PhFirst, PhNext: begin
            if (symbol_i == SymDot) begin
              phase_d = PhDoneAllele;
            end else if (is_digit) begin
              accum_d = AccumW'(digit);
              phase_d = PhIndex;
            end else begin
              err_code_d = StExpected;
              err_off_d  = pos_q;
              phase_d    = PhSkip;
            end
          end
          PhIndex, PhDoneAllele: begin
            if ((phase_q == PhIndex) && is_digit) begin
              accum_d = AccumW'(accum_next);
              if (accum_next > (AccumW+4)'(IndexLimit)) begin
                err_code_d = StOverflow;
                err_off_d  = pos_q;
                phase_d    = PhSkip;
              end
            end else if ((phase_q == PhIndex) && above_max) begin
              err_code_d = StAboveMax;
              err_off_d  = '0;
              phase_d    = PhSkip;
            end else if (sym_sep == SepNone) begin
              err_code_d = StAfter;
              err_off_d  = pos_q;
              phase_d    = PhSkip;
            end else if ((sep_q != SepNone) && (sep_q != sym_sep)) begin
              err_code_d = StMixed;
              err_off_d  = pos_q;
              phase_d    = PhSkip;
            end else begin
              sep_d   = sym_sep;
              phase_d = PhNext;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhFirst;
      accum_q    <= '0;
      sep_q      <= SepNone;
      pos_q      <= '0;
      err_code_q <= StOk;
      err_off_q  <= '0;
    end else begin
      phase_q    <= phase_d;
      accum_q    <= accum_d;
      sep_q      <= sep_d;
      pos_q      <= pos_d;
      err_code_q <= err_code_d;
      err_off_q  <= err_off_d;
    end
  end

endmodule

### src/genotype_field_validator.sv
// Genotype field validator: takes one text byte per item, reports one result per string.
// A result appears on the output in the cycle after its terminating zero byte is taken.
// Throughput: one byte per cycle while the input is not stalled; the parser state update is a single registered step.
// The input stalls only while a finished result waits in the output register and is not taken.
// Reset clears the parser, empties the output register and sets the maximum index to 1000000.
module genotype_field_validator #(
  parameter int MAX_LEN = 65535
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gtv_pkg::MaxIdxW-1:0] cfg_wdata_i,   // max_allele_index
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] symbol
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [23:0]                 m_axis_tdata   // [2:0] status, [18:3] error_offset
);
  import gtv_pkg::*;

  logic [MaxIdxW-1:0] max_idx_q;
  logic               m_valid_q, m_valid_d;
  gtv_result_t        res_q, res_d;
  gtv_result_t        core_res;
  logic               core_valid;
  logic               in_accept;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  gtv_parse_core #(
    .MAX_LEN(MAX_LEN)
  ) u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (in_accept),
    .symbol_i           (s_axis_tdata),
    .max_allele_index_i (max_idx_q),
    .result_valid_o     (core_valid),
    .result_o           (core_res)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    res_d     = res_q;
    if (core_valid) begin
      m_valid_d = 1'b1;
      res_d     = core_res;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      max_idx_q <= MaxIdxReset;
    end else begin
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        max_idx_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b00000, res_q.error_offset, res_q.status};

endmodule

### src/gtv_checker.sv
// Port-level checks of the genotype field validator, bound to its top level.
module gtv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  import gtv_pkg::*;

  logic               in_acc;
  logic [StatusW-1:0] st;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign st     = m_axis_tdata[StatusW-1:0];

  // A terminating byte always yields a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (s_axis_tdata == SymNul)) |=> m_axis_tvalid)
    else $error("no result after terminating item");

  // Any other byte taken while the output is empty produces nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (s_axis_tdata != SymNul) && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result without terminating item");

  // The input stalls only behind a result that is not being taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without cause");

  // Statuses without a position carry a zero offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ((st == StOk) || (st == StEmpty) || (st == StAboveMax)))
      |-> (m_axis_tdata[18:3] == '0))
    else $error("nonzero offset on positionless status");

  // A result held back keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind genotype_field_validator gtv_checker u_gtv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
